/* rtl/core/tgld_pkg.sv */
// ----------------------------------------------------------------------------
// tgld_pkg
// Shared widths, command codes and decode types of the text grid line
// insert/delete core.
// ----------------------------------------------------------------------------
`default_nettype none

package tgld_pkg;

    localparam int ROW_W  = 6;
    localparam int COL_W  = 7;
    localparam int ADDR_W = ROW_W + COL_W;
    localparam int CELL_W = 32;
    localparam int KIND_W = 3;
    localparam int CNT_W  = 7;
    localparam int LIM_W  = 7;
    localparam int ROWS_W = 7;
    localparam int COLS_W = 8;
    localparam int CFG_W  = 8;

    localparam logic [ROWS_W-1:0] MAX_ROWS   = ROWS_W'(64);
    localparam logic [COLS_W-1:0] MAX_COLS   = COLS_W'(128);
    localparam logic [ROWS_W-1:0] ROWS_RESET = ROWS_W'(24);
    localparam logic [COLS_W-1:0] COLS_RESET = COLS_W'(80);

    localparam logic [KIND_W-1:0] KIND_READ   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE  = 3'd1;
    localparam logic [KIND_W-1:0] KIND_INSERT = 3'd2;
    localparam logic [KIND_W-1:0] KIND_DELETE = 3'd3;
    localparam logic [KIND_W-1:0] KIND_FILL   = 3'd4;

    localparam logic CFG_ROWS = 1'b0;
    localparam logic CFG_COLS = 1'b1;

    typedef enum logic [2:0] {
        OP_NONE  = 3'd0,
        OP_READ  = 3'd1,
        OP_WRITE = 3'd2,
        OP_LINES = 3'd3,
        OP_FILL  = 3'd4
    } op_t;

    typedef struct packed {
        op_t               op;
        logic              status;
        logic              copy_en;
        logic              copy_down;
        logic [ROW_W-1:0]  copy_first;
        logic [ROW_W-1:0]  copy_last;
        logic [ROW_W-1:0]  shift;
        logic [ADDR_W-1:0] fill_first;
        logic [ADDR_W-1:0] fill_last;
        logic [ADDR_W-1:0] cell_addr;
    } dec_t;

endpackage

`default_nettype wire

/* rtl/core/tgld_decode.sv */
// ----------------------------------------------------------------------------
// tgld_decode
// Command decode: clips the grid size, bounds the scroll region and works
// out the row ranges for the copy and fill sweeps of one command.
// ----------------------------------------------------------------------------
`default_nettype none

module tgld_decode (
    input  wire logic [tgld_pkg::ROWS_W-1:0] rows_cfg,
    input  wire logic [tgld_pkg::COLS_W-1:0] cols_cfg,
    input  wire logic [tgld_pkg::KIND_W-1:0] kind,
    input  wire logic [tgld_pkg::ROW_W-1:0]  row,
    input  wire logic [tgld_pkg::COL_W-1:0]  col,
    input  wire logic [tgld_pkg::CNT_W-1:0]  line_count,
    input  wire logic                        has_limit,
    input  wire logic [tgld_pkg::LIM_W-1:0]  limit_row,
    output tgld_pkg::dec_t                   dec
);

    logic [tgld_pkg::ROWS_W-1:0] eff_rows;
    logic [tgld_pkg::COLS_W-1:0] eff_cols;
    logic [tgld_pkg::LIM_W-1:0]  limit;
    logic                        cell_ok;
    logic                        lines_ok;
    logic                        copy_en;
    logic [7:0]                  row_x;
    logic [7:0]                  cnt_x;
    logic [7:0]                  lim_x;
    logic [7:0]                  end_x;
    logic [7:0]                  lim_m1;
    logic [7:0]                  ins_fill_end;
    logic [7:0]                  del_fill_first;
    logic [7:0]                  del_copy_last;
    logic [tgld_pkg::ROW_W-1:0]  fill_lo;
    logic [tgld_pkg::ROW_W-1:0]  fill_hi;

    always_comb begin
        if (rows_cfg == '0) begin
            eff_rows = tgld_pkg::ROWS_W'(1);
        end else if (rows_cfg > tgld_pkg::MAX_ROWS) begin
            eff_rows = tgld_pkg::MAX_ROWS;
        end else begin
            eff_rows = rows_cfg;
        end

        if (cols_cfg == '0) begin
            eff_cols = tgld_pkg::COLS_W'(1);
        end else if (cols_cfg > tgld_pkg::MAX_COLS) begin
            eff_cols = tgld_pkg::MAX_COLS;
        end else begin
            eff_cols = cols_cfg;
        end

        limit = (has_limit && (limit_row < eff_rows)) ? limit_row : eff_rows;
        cell_ok = ({1'b0, row} < eff_rows) && ({1'b0, col} < eff_cols);

        row_x  = {2'b00, row};
        cnt_x  = {1'b0, line_count};
        lim_x  = {1'b0, limit};
        end_x  = row_x + cnt_x;
        lim_m1 = lim_x - 8'd1;

        lines_ok = ({1'b0, row} < limit) && (line_count != '0);
        copy_en  = end_x < lim_x;

        ins_fill_end   = copy_en ? end_x : lim_x;
        del_fill_first = copy_en ? (lim_x - cnt_x) : row_x;
        del_copy_last  = lim_x - cnt_x - 8'd1;

        dec            = '0;
        dec.op         = tgld_pkg::OP_NONE;
        dec.status     = 1'b1;
        dec.copy_en    = copy_en;
        dec.shift      = line_count[tgld_pkg::ROW_W-1:0];
        dec.cell_addr  = {row, col};
        fill_lo        = row;
        fill_hi        = lim_m1[tgld_pkg::ROW_W-1:0];

        unique case (kind)
            tgld_pkg::KIND_READ: begin
                dec.op     = cell_ok ? tgld_pkg::OP_READ : tgld_pkg::OP_NONE;
                dec.status = !cell_ok;
            end
            tgld_pkg::KIND_WRITE: begin
                dec.op     = cell_ok ? tgld_pkg::OP_WRITE : tgld_pkg::OP_NONE;
                dec.status = !cell_ok;
            end
            tgld_pkg::KIND_INSERT: begin
                dec.op         = lines_ok ? tgld_pkg::OP_LINES : tgld_pkg::OP_NONE;
                dec.status     = !lines_ok;
                dec.copy_down  = 1'b1;
                dec.copy_first = lim_m1[tgld_pkg::ROW_W-1:0];
                dec.copy_last  = end_x[tgld_pkg::ROW_W-1:0];
                fill_lo        = row;
                fill_hi        = 6'(ins_fill_end - 8'd1);
            end
            tgld_pkg::KIND_DELETE: begin
                dec.op         = lines_ok ? tgld_pkg::OP_LINES : tgld_pkg::OP_NONE;
                dec.status     = !lines_ok;
                dec.copy_down  = 1'b0;
                dec.copy_first = row;
                dec.copy_last  = del_copy_last[tgld_pkg::ROW_W-1:0];
                fill_lo        = del_fill_first[tgld_pkg::ROW_W-1:0];
                fill_hi        = lim_m1[tgld_pkg::ROW_W-1:0];
            end
            tgld_pkg::KIND_FILL: begin
                dec.op     = tgld_pkg::OP_FILL;
                dec.status = 1'b0;
            end
            default: begin
                dec.op     = tgld_pkg::OP_NONE;
                dec.status = 1'b1;
            end
        endcase

        if (kind == tgld_pkg::KIND_FILL) begin
            dec.fill_first = '0;
            dec.fill_last  = '1;
        end else begin
            dec.fill_first = {fill_lo, {tgld_pkg::COL_W{1'b0}}};
            dec.fill_last  = {fill_hi, {tgld_pkg::COL_W{1'b1}}};
        end
    end

endmodule

`default_nettype wire

/* rtl/core/text_grid_line_insert_delete_core.sv */
// ----------------------------------------------------------------------------
// text_grid_line_insert_delete_core
// Terminal character-cell store (64 rows x 128 columns of 32-bit cells)
// with cell read/write, line insert/delete inside a scroll region and fill.
//
// Usage:
//   Commands enter on the s_ channel (valid/ready), one result per command
//   leaves on the m_ channel from an output register. Grid size comes from
//   cfg_wr_en/cfg_index/cfg_wdata: index 0 rows in use, 1 columns in use.
//   One cell moves per cycle through a single-port-read, single-port-write
//   store with a one-deep write stage. A command runs through these steps:
//     read cell   : registered store read, then the result register
//     write cell  : one write-stage write; out of range / no-op: none
//     insert/del  : 128 cells per row moved, then per row filled
//     fill all    : every cell of the store written
//   s_ready is high only while idle; one command is in flight at a time.
//   After reset the store is swept to zero, every cell written, with s_ready
//   low until the last write has drained out of the write stage;
//   configuration writes are taken during the sweep.
//   A stalled receiver holds the result in the output register; the next
//   command is still accepted and its result waits until the register frees.
// ----------------------------------------------------------------------------
`default_nettype none

module text_grid_line_insert_delete_core (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,

    input  wire logic                        cfg_wr_en,
    input  wire logic                        cfg_index,
    input  wire logic [tgld_pkg::CFG_W-1:0]  cfg_wdata,

    input  wire logic                        s_valid,
    output logic                             s_ready,
    input  wire logic [tgld_pkg::KIND_W-1:0] s_kind,
    input  wire logic [tgld_pkg::ROW_W-1:0]  s_row,
    input  wire logic [tgld_pkg::COL_W-1:0]  s_col,
    input  wire logic [tgld_pkg::CNT_W-1:0]  s_line_count,
    input  wire logic                        s_has_limit,
    input  wire logic [tgld_pkg::LIM_W-1:0]  s_limit_row,
    input  wire logic [tgld_pkg::CELL_W-1:0] s_cell_value,

    output logic                             m_valid,
    input  wire logic                        m_ready,
    output logic [tgld_pkg::CELL_W-1:0]      m_read_data,
    output logic                             m_status
);

    localparam int DEPTH = 1 << tgld_pkg::ADDR_W;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_READ = 5'b00010,
        ST_COPY = 5'b00100,
        ST_FILL = 5'b01000,
        ST_RESP = 5'b10000
    } state_t;

    state_t                        state_reg, state_next;
    logic [tgld_pkg::ROWS_W-1:0]   rows_cfg_reg;
    logic [tgld_pkg::COLS_W-1:0]   cols_cfg_reg;
    logic                          clear_reg, clear_next;
    logic [tgld_pkg::ROW_W-1:0]    dst_row_reg, dst_row_next;
    logic [tgld_pkg::COL_W-1:0]    col_reg, col_next;
    logic [tgld_pkg::ADDR_W-1:0]   addr_reg, addr_next;
    tgld_pkg::dec_t                dec_reg, dec_next;
    logic [tgld_pkg::CELL_W-1:0]   value_reg, value_next;
    logic [tgld_pkg::CELL_W-1:0]   res_data_reg, res_data_next;

    logic                          wr_valid_reg, wr_valid_next;
    logic                          wr_copy_reg, wr_copy_next;
    logic [tgld_pkg::ADDR_W-1:0]   wr_addr_reg, wr_addr_next;
    logic [tgld_pkg::CELL_W-1:0]   wr_data_reg, wr_data_next;
    logic [tgld_pkg::CELL_W-1:0]   rdata_reg;

    logic                          m_valid_reg, m_valid_next;
    logic [tgld_pkg::CELL_W-1:0]   m_read_data_reg, m_read_data_next;
    logic                          m_status_reg, m_status_next;

    logic [tgld_pkg::CELL_W-1:0]   mem [DEPTH];

    tgld_pkg::dec_t                dec;
    logic [tgld_pkg::ROW_W-1:0]    src_row;
    logic [tgld_pkg::ADDR_W-1:0]   rd_addr;
    logic [tgld_pkg::ADDR_W-1:0]   fill_end;
    logic                          s_xfer;

    tgld_decode u_decode (
        .rows_cfg   (rows_cfg_reg),
        .cols_cfg   (cols_cfg_reg),
        .kind       (s_kind),
        .row        (s_row),
        .col        (s_col),
        .line_count (s_line_count),
        .has_limit  (s_has_limit),
        .limit_row  (s_limit_row),
        .dec        (dec)
    );

    // hold off while the last clear write is still in the write stage
    assign s_ready     = (state_reg == ST_IDLE) && !wr_valid_reg;
    assign s_xfer      = s_valid && s_ready;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_read_data_reg;
    assign m_status    = m_status_reg;

    assign src_row  = dec_reg.copy_down ? (dst_row_reg - dec_reg.shift)
                                        : (dst_row_reg + dec_reg.shift);
    assign rd_addr  = (state_reg == ST_IDLE) ? dec.cell_addr : {src_row, col_reg};
    assign fill_end = clear_reg ? '1 : dec_reg.fill_last;

    always_comb begin
        state_next       = state_reg;
        clear_next       = clear_reg;
        dst_row_next     = dst_row_reg;
        col_next         = col_reg;
        addr_next        = addr_reg;
        dec_next         = dec_reg;
        value_next       = value_reg;
        res_data_next    = res_data_reg;
        wr_valid_next    = 1'b0;
        wr_copy_next     = 1'b0;
        wr_addr_next     = wr_addr_reg;
        wr_data_next     = wr_data_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_read_data_next = m_read_data_reg;
        m_status_next    = m_status_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_xfer) begin
                    dec_next      = dec;
                    value_next    = s_cell_value;
                    res_data_next = '0;
                    dst_row_next  = dec.copy_first;
                    col_next      = '0;
                    addr_next     = dec.fill_first;
                    case (dec.op)
                        tgld_pkg::OP_READ: begin
                            state_next = ST_READ;
                        end
                        tgld_pkg::OP_WRITE: begin
                            wr_valid_next = 1'b1;
                            wr_addr_next  = dec.cell_addr;
                            wr_data_next  = s_cell_value;
                            state_next    = ST_RESP;
                        end
                        tgld_pkg::OP_LINES: begin
                            state_next = dec.copy_en ? ST_COPY : ST_FILL;
                        end
                        tgld_pkg::OP_FILL: begin
                            state_next = ST_FILL;
                        end
                        default: begin
                            state_next = ST_RESP;
                        end
                    endcase
                end
            end
            ST_READ: begin
                res_data_next = rdata_reg;
                state_next    = ST_RESP;
            end
            ST_COPY: begin
                wr_valid_next = 1'b1;
                wr_copy_next  = 1'b1;
                wr_addr_next  = {dst_row_reg, col_reg};
                col_next      = col_reg + 1'b1;
                if (col_reg == '1) begin
                    if (dst_row_reg == dec_reg.copy_last) begin
                        state_next = ST_FILL;
                    end else if (dec_reg.copy_down) begin
                        dst_row_next = dst_row_reg - 1'b1;
                    end else begin
                        dst_row_next = dst_row_reg + 1'b1;
                    end
                end
            end
            ST_FILL: begin
                wr_valid_next = 1'b1;
                wr_addr_next  = addr_reg;
                wr_data_next  = clear_reg ? '0 : value_reg;
                addr_next     = addr_reg + 1'b1;
                if (addr_reg == fill_end) begin
                    if (clear_reg) begin
                        clear_next = 1'b0;
                        state_next = ST_IDLE;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next     = 1'b1;
                    m_read_data_next = res_data_reg;
                    m_status_next    = dec_reg.status;
                    state_next       = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_FILL;
            clear_reg    <= 1'b1;
            addr_reg     <= '0;
            dst_row_reg  <= '0;
            col_reg      <= '0;
            wr_valid_reg <= 1'b0;
            wr_copy_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            rows_cfg_reg <= tgld_pkg::ROWS_RESET;
            cols_cfg_reg <= tgld_pkg::COLS_RESET;
        end else begin
            state_reg    <= state_next;
            clear_reg    <= clear_next;
            addr_reg     <= addr_next;
            dst_row_reg  <= dst_row_next;
            col_reg      <= col_next;
            wr_valid_reg <= wr_valid_next;
            wr_copy_reg  <= wr_copy_next;
            m_valid_reg  <= m_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    tgld_pkg::CFG_ROWS: rows_cfg_reg <= cfg_wdata[tgld_pkg::ROWS_W-1:0];
                    tgld_pkg::CFG_COLS: cols_cfg_reg <= cfg_wdata;
                    default:            rows_cfg_reg <= rows_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        dec_reg         <= dec_next;
        value_reg       <= value_next;
        res_data_reg    <= res_data_next;
        wr_addr_reg     <= wr_addr_next;
        wr_data_reg     <= wr_data_next;
        m_read_data_reg <= m_read_data_next;
        m_status_reg    <= m_status_next;
    end

    // cell store: one write from the write stage, one registered read
    always_ff @(posedge aclk) begin
        if (wr_valid_reg) begin
            mem[wr_addr_reg] <= wr_copy_reg ? rdata_reg : wr_data_reg;
        end
        rdata_reg <= mem[rd_addr];
    end

    a_clear_no_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        clear_reg |-> !s_ready)
        else $error("command accepted during store clear");

    a_clear_once: assert property (@(posedge aclk) disable iff (!aresetn)
        !clear_reg |=> !clear_reg)
        else $error("store clear restarted");

    a_copy_rows_differ: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY) |-> (src_row != dst_row_reg))
        else $error("row copy onto itself");

    a_copy_write_source: assert property (@(posedge aclk) disable iff (!aresetn)
        wr_copy_reg |-> $past(state_reg == ST_COPY))
        else $error("copy write without a copy read");

    a_result_from_resp: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(state_reg == ST_RESP))
        else $error("result transfer raised outside response state");

endmodule

`default_nettype wire
